### sv/vector_angle_3d_assert.svh
// Assertion macros shared by the angle block
`ifndef VECTOR_ANGLE_3D_ASSERT_SVH
`define VECTOR_ANGLE_3D_ASSERT_SVH

// Same-cycle implication, sampled on the block clock, idle in reset
`define VANG_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication
`define VANG_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

### sv/vang_pkg.sv
// ----------------------------------------------------------------------------
// vang_pkg
// Shared types and constants of the 3D vector angle pipeline.
// ----------------------------------------------------------------------------
package vang_pkg;

   localparam int CORDIC_STEPS = 24;

   localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
   localparam logic [31:0] ONE_Q28     = 32'h1000_0000;
   localparam logic [61:0] ONE_Q60     = 62'h1000_0000_0000_0000;
   localparam logic [25:0] PI_Q24      = 26'd52707179;
   localparam logic [25:0] HALF_PI_Q24 = 26'd26353589;
   localparam logic [26:0] ROUND_HALF  = 27'd1024;
   localparam logic [14:0] ANGLE_MAX   = 15'd25736;

   localparam logic [2:0]  ADDR_UNIT_MODE = 3'd0;

   localparam logic [23:0] ATAN_Q24 [CORDIC_STEPS] = '{
      24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214, 24'd524117,
      24'd262123, 24'd131069, 24'd65536, 24'd32768, 24'd16384, 24'd8192,
      24'd4096, 24'd2048, 24'd1024, 24'd512, 24'd256, 24'd128,
      24'd64, 24'd32, 24'd16, 24'd8, 24'd4, 24'd2
   };

   // side data that rides along the magnitude root and the divider
   typedef struct packed {
      logic        neg;
      logic        degen;
      logic        unit_sel;
      logic [31:0] ad;
   } vang_mag_tag_type;

   // side data that rides along the sine root
   typedef struct packed {
      logic        neg;
      logic        degen;
      logic [30:0] c;
   } vang_ang_tag_type;

   // side data that rides along the CORDIC
   typedef struct packed {
      logic neg;
      logic degen;
   } vang_rot_tag_type;

   typedef struct packed {
      logic [14:0] angle;
      logic        degenerate;
   } vang_rsp_type;

endpackage

### sv/vang_if.sv
// ----------------------------------------------------------------------------
// vang_req_if / vang_rsp_if
// Valid/ready channels carrying vector pairs in and angles out.
// ----------------------------------------------------------------------------
interface vang_req_if #(parameter int COMPONENT_BITS = 16);
   logic                             valid;
   logic                             ready;
   logic signed [COMPONENT_BITS-1:0] u_x;
   logic signed [COMPONENT_BITS-1:0] u_y;
   logic signed [COMPONENT_BITS-1:0] u_z;
   logic signed [COMPONENT_BITS-1:0] v_x;
   logic signed [COMPONENT_BITS-1:0] v_y;
   logic signed [COMPONENT_BITS-1:0] v_z;

   modport source (output valid, u_x, u_y, u_z, v_x, v_y, v_z, input ready);
   modport sink   (input valid, u_x, u_y, u_z, v_x, v_y, v_z, output ready);
endinterface

interface vang_rsp_if;
   logic        valid;
   logic        ready;
   logic [14:0] angle;
   logic        degenerate;

   modport source (output valid, angle, degenerate, input ready);
   modport sink   (input valid, angle, degenerate, output ready);
endinterface

### sv/vang_isqrt.sv
// ----------------------------------------------------------------------------
// vang_isqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module vang_isqrt #(
   parameter int W  = 64,
   parameter int TW = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [W-1:0]     in_val,
   input  logic [TW-1:0]    in_tag,
   output logic             out_valid,
   output logic [W/2-1:0]   out_root,
   output logic [TW-1:0]    out_tag
);
   localparam int K = W / 2;

   logic [W-1:0]  n_ff   [K];
   logic [W-1:0]  r_ff   [K];
   logic [TW-1:0] tag_ff [K];
   logic [K-1:0]  v_ff;

   genvar g;
   generate
      for (g = 0; g < K; g++) begin : g_stage
         localparam logic [W:0] B = {{W{1'b0}}, 1'b1} << (W - 2 - 2 * g);
         logic [W-1:0]  n_prev;
         logic [W-1:0]  r_prev;
         logic [TW-1:0] t_prev;
         logic          v_prev;
         logic [W:0]    trial;
         logic [W-1:0]  n_in;
         logic [W-1:0]  r_in;

         if (g == 0) begin : g_first
            assign n_prev = in_val;
            assign r_prev = '0;
            assign t_prev = in_tag;
            assign v_prev = in_valid;
         end else begin : g_next
            assign n_prev = n_ff[g-1];
            assign r_prev = r_ff[g-1];
            assign t_prev = tag_ff[g-1];
            assign v_prev = v_ff[g-1];
         end

         assign trial = {1'b0, r_prev} + B;

         always_comb begin
            if ({1'b0, n_prev} >= trial) begin
               n_in = n_prev - trial[W-1:0];
               r_in = (r_prev >> 1) + B[W-1:0];
            end else begin
               n_in = n_prev;
               r_in = r_prev >> 1;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[g] <= 1'b0;
            end else if (en) begin
               v_ff[g] <= v_prev;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               n_ff[g]   <= n_in;
               r_ff[g]   <= r_in;
               tag_ff[g] <= t_prev;
            end
         end
      end
   endgenerate

   assign out_valid = v_ff[K-1];
   assign out_root  = r_ff[K-1][K-1:0];
   assign out_tag   = tag_ff[K-1];

endmodule

### sv/vang_div.sv
// ----------------------------------------------------------------------------
// vang_div
// Pipelined restoring divider: (ad << 30) / den, one quotient bit per stage,
// with an overflow flag when the quotient would reach 2^31.
// ----------------------------------------------------------------------------
module vang_div #(
   parameter int TW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [31:0]   in_ad,
   input  logic [31:0]   in_den,
   input  logic [TW-1:0] in_tag,
   output logic          out_valid,
   output logic          out_sat,
   output logic [30:0]   out_q,
   output logic [TW-1:0] out_tag
);
   localparam int QB = 31;

   // overflow check stage
   logic          chk_v_ff;
   logic [61:0]   chk_rem_ff;
   logic [31:0]   chk_den_ff;
   logic          chk_sat_ff;
   logic [TW-1:0] chk_tag_ff;
   logic [61:0]   num_in;
   logic          sat_in;

   assign num_in = {in_ad, 30'b0};
   assign sat_in = {1'b0, num_in} >= {in_den, 31'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_v_ff <= 1'b0;
      end else if (en) begin
         chk_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         chk_rem_ff <= num_in;
         chk_den_ff <= in_den;
         chk_sat_ff <= sat_in;
         chk_tag_ff <= in_tag;
      end
   end

   logic [61:0]   rem_ff [QB];
   logic [31:0]   den_ff [QB];
   logic [30:0]   q_ff   [QB];
   logic [TW-1:0] tag_ff [QB];
   logic [QB-1:0] sat_ff;
   logic [QB-1:0] v_ff;

   genvar g;
   generate
      for (g = 0; g < QB; g++) begin : g_stage
         localparam int POS = QB - 1 - g;
         logic [61:0]   rem_prev;
         logic [31:0]   den_prev;
         logic [30:0]   q_prev;
         logic [TW-1:0] t_prev;
         logic          s_prev;
         logic          v_prev;
         logic [61:0]   dsh;
         logic [61:0]   rem_in;
         logic [30:0]   q_in;

         if (g == 0) begin : g_first
            assign rem_prev = chk_rem_ff;
            assign den_prev = chk_den_ff;
            assign q_prev   = '0;
            assign t_prev   = chk_tag_ff;
            assign s_prev   = chk_sat_ff;
            assign v_prev   = chk_v_ff;
         end else begin : g_next
            assign rem_prev = rem_ff[g-1];
            assign den_prev = den_ff[g-1];
            assign q_prev   = q_ff[g-1];
            assign t_prev   = tag_ff[g-1];
            assign s_prev   = sat_ff[g-1];
            assign v_prev   = v_ff[g-1];
         end

         assign dsh = {30'b0, den_prev} << POS;

         always_comb begin
            if (rem_prev >= dsh) begin
               rem_in = rem_prev - dsh;
               q_in   = q_prev | (31'd1 << POS);
            end else begin
               rem_in = rem_prev;
               q_in   = q_prev;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[g] <= 1'b0;
            end else if (en) begin
               v_ff[g] <= v_prev;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[g] <= rem_in;
               den_ff[g] <= den_prev;
               q_ff[g]   <= q_in;
               tag_ff[g] <= t_prev;
               sat_ff[g] <= s_prev;
            end
         end
      end
   endgenerate

   assign out_valid = v_ff[QB-1];
   assign out_sat   = sat_ff[QB-1];
   assign out_q     = q_ff[QB-1];
   assign out_tag   = tag_ff[QB-1];

endmodule

### sv/vang_cordic.sv
// ----------------------------------------------------------------------------
// vang_cordic
// Pipelined CORDIC in vectoring mode: atan2(y, x) in 2^-24 rad.
// ----------------------------------------------------------------------------
module vang_cordic #(
   parameter int TW = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [30:0]        in_x,
   input  logic [30:0]        in_y,
   input  logic [TW-1:0]      in_tag,
   output logic               out_valid,
   output logic signed [26:0] out_z,
   output logic [TW-1:0]      out_tag
);
   localparam int N = vang_pkg::CORDIC_STEPS;

   logic signed [33:0] x_ff   [N];
   logic signed [33:0] y_ff   [N];
   logic signed [26:0] z_ff   [N];
   logic [TW-1:0]      tag_ff [N];
   logic [N-1:0]       v_ff;

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_stage
         logic signed [33:0] x_prev;
         logic signed [33:0] y_prev;
         logic signed [26:0] z_prev;
         logic [TW-1:0]      t_prev;
         logic               v_prev;
         logic signed [33:0] xs;
         logic signed [33:0] ys;
         logic signed [26:0] at;
         logic signed [33:0] x_in;
         logic signed [33:0] y_in;
         logic signed [26:0] z_in;

         if (g == 0) begin : g_first
            assign x_prev = $signed({3'b0, in_x});
            assign y_prev = $signed({3'b0, in_y});
            assign z_prev = '0;
            assign t_prev = in_tag;
            assign v_prev = in_valid;
         end else begin : g_next
            assign x_prev = x_ff[g-1];
            assign y_prev = y_ff[g-1];
            assign z_prev = z_ff[g-1];
            assign t_prev = tag_ff[g-1];
            assign v_prev = v_ff[g-1];
         end

         assign xs = x_prev >>> g;
         assign ys = y_prev >>> g;
         assign at = $signed({3'b0, vang_pkg::ATAN_Q24[g]});

         // rotate towards the x axis
         always_comb begin
            if (y_prev > 0) begin
               x_in = x_prev + ys;
               y_in = y_prev - xs;
               z_in = z_prev + at;
            end else begin
               x_in = x_prev - ys;
               y_in = y_prev + xs;
               z_in = z_prev - at;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[g] <= 1'b0;
            end else if (en) begin
               v_ff[g] <= v_prev;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[g]   <= x_in;
               y_ff[g]   <= y_in;
               z_ff[g]   <= z_in;
               tag_ff[g] <= t_prev;
            end
         end
      end
   endgenerate

   assign out_valid = v_ff[N-1];
   assign out_z     = z_ff[N-1];
   assign out_tag   = tag_ff[N-1];

endmodule

### sv/vang_outbuf.sv
// ----------------------------------------------------------------------------
// vang_outbuf
// Two-entry output buffer; full is registered so the pipeline stall does not
// depend combinationally on the receiver's ready.
// ----------------------------------------------------------------------------
module vang_outbuf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  vang_pkg::vang_rsp_type push_data,
   output logic                  full,
   output logic                  out_valid,
   input  logic                  out_ready,
   output vang_pkg::vang_rsp_type out_data
);
   logic [1:0]             count_ff;
   logic [1:0]             count_in;
   vang_pkg::vang_rsp_type slot0_ff;
   vang_pkg::vang_rsp_type slot1_ff;
   vang_pkg::vang_rsp_type slot0_in;
   vang_pkg::vang_rsp_type slot1_in;
   logic                   pop;

   assign pop = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (pop && !push) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end else if (push && !pop) begin
         if (count_ff == 2'd0) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
         count_in = count_ff + 2'd1;
      end else if (push && pop) begin
         if (count_ff == 2'd1) begin
            slot0_in = push_data;
         end else begin
            slot0_in = slot1_ff;
            slot1_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot0_ff;

endmodule

### sv/vector_angle_3d.sv
// ----------------------------------------------------------------------------
// vector_angle_3d
// Angle between two 3D vectors: acos of the normalised dot product, Q2.13.
// ----------------------------------------------------------------------------
// req_ch carries one vector pair per item (signed Q1.14 at 16-bit components);
// rsp_ch returns one item per input: angle (0..pi, Q2.13) and degenerate.
// One item can be taken every cycle while the output buffer is not full. There
// are 125 register stages: three product/sum stages, 32 stages of the magnitude
// root, 32 divider stages, two cosine stages, 31 stages of the sine root, 24
// CORDIC stages and the output buffer.
// The CSR port holds unit_mode at address 0; when set, the dot product is
// taken directly as the cosine and the divider result is not used. Write it while idle.
// Reset clears every stage valid bit, the output buffer and unit_mode.
// When rsp_ch stalls, results collect in a two-entry output buffer; once it is
// full the whole pipeline holds and req_ch.ready drops, so nothing is lost.
// ----------------------------------------------------------------------------
`include "vector_angle_3d_assert.svh"

module vector_angle_3d #(
   parameter int COMPONENT_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   vang_req_if.sink      req_ch,
   vang_rsp_if.source    rsp_ch,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [2:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);
   localparam int MAG_TW = $bits(vang_pkg::vang_mag_tag_type);
   localparam int ANG_TW = $bits(vang_pkg::vang_ang_tag_type);
   localparam int ROT_TW = $bits(vang_pkg::vang_rot_tag_type);

   logic en;
   logic buf_full;

   // configuration
   logic unit_mode_ff;
   logic csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == vang_pkg::ADDR_UNIT_MODE[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_mode_ff <= 1'b0;
      end else if (csr_wr) begin
         unit_mode_ff <= csr_pwdata[0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == vang_pkg::ADDR_UNIT_MODE[2])
                       ? {31'b0, unit_mode_ff} : 32'b0;

   assign en           = !buf_full;
   assign req_ch.ready = en;

   // bring components to Q1.14
   logic [COMPONENT_BITS-1:0] raw [6];
   logic signed [15:0]        q14 [6];

   assign raw[0] = req_ch.u_x;
   assign raw[1] = req_ch.u_y;
   assign raw[2] = req_ch.u_z;
   assign raw[3] = req_ch.v_x;
   assign raw[4] = req_ch.v_y;
   assign raw[5] = req_ch.v_z;

   genvar i;
   generate
      for (i = 0; i < 6; i++) begin : g_q14
         if (COMPONENT_BITS > 16) begin : g_wide
            assign q14[i] = $signed(raw[i][COMPONENT_BITS-1 -: 16]);
         end else if (COMPONENT_BITS == 16) begin : g_same
            assign q14[i] = $signed(raw[i]);
         end else begin : g_narrow
            assign q14[i] = $signed({raw[i], {(16 - COMPONENT_BITS){1'b0}}});
         end
      end
   endgenerate

   // stage 1: products
   logic               s1_v_ff;
   logic signed [31:0] pd_ff [3];
   logic [30:0]        pu_ff [3];
   logic [30:0]        pv_ff [3];
   logic signed [31:0] pd_in [3];
   logic signed [31:0] pu_in [3];
   logic signed [31:0] pv_in [3];

   generate
      for (i = 0; i < 3; i++) begin : g_prod
         assign pd_in[i] = q14[i] * q14[i+3];
         assign pu_in[i] = q14[i] * q14[i];
         assign pv_in[i] = q14[i+3] * q14[i+3];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            pd_ff[k] <= pd_in[k];
            pu_ff[k] <= pu_in[k][30:0];
            pv_ff[k] <= pv_in[k][30:0];
         end
      end
   end

   // stage 2: sums
   logic               s2_v_ff;
   logic signed [33:0] d_ff;
   logic [31:0]        su_ff;
   logic [31:0]        sv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff  <= 34'(pd_ff[0]) + 34'(pd_ff[1]) + 34'(pd_ff[2]);
         su_ff <= {1'b0, pu_ff[0]} + {1'b0, pu_ff[1]} + {1'b0, pu_ff[2]};
         sv_ff <= {1'b0, pv_ff[0]} + {1'b0, pv_ff[1]} + {1'b0, pv_ff[2]};
      end
   end

   // stage 3: magnitude product, |d|, flags
   logic                       s3_v_ff;
   logic [63:0]                prod_ff;
   vang_pkg::vang_mag_tag_type s3_tag_ff;
   vang_pkg::vang_mag_tag_type s3_tag_in;
   logic signed [33:0]         ad_full;

   assign ad_full            = (d_ff < 0) ? -d_ff : d_ff;
   assign s3_tag_in.neg      = (d_ff < 0);
   assign s3_tag_in.degen    = !unit_mode_ff && ((su_ff == 32'd0) || (sv_ff == 32'd0));
   assign s3_tag_in.unit_sel = unit_mode_ff;
   assign s3_tag_in.ad       = ad_full[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff   <= su_ff * sv_ff;
         s3_tag_ff <= s3_tag_in;
      end
   end

   // magnitude root
   logic                       rt1_v;
   logic [31:0]                rt1_root;
   vang_pkg::vang_mag_tag_type rt1_tag;

   vang_isqrt #(.W(64), .TW(MAG_TW)) u_mag_root (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_v_ff),
      .in_val    (prod_ff),
      .in_tag    (s3_tag_ff),
      .out_valid (rt1_v),
      .out_root  (rt1_root),
      .out_tag   (rt1_tag)
   );

   // cosine division
   logic                       dv_v;
   logic                       dv_sat;
   logic [30:0]                dv_q;
   vang_pkg::vang_mag_tag_type dv_tag;
   logic [31:0]                den;

   assign den = (rt1_root == 32'd0) ? 32'd1 : rt1_root;

   vang_div #(.TW(MAG_TW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rt1_v),
      .in_ad     (rt1_tag.ad),
      .in_den    (den),
      .in_tag    (rt1_tag),
      .out_valid (dv_v),
      .out_sat   (dv_sat),
      .out_q     (dv_q),
      .out_tag   (dv_tag)
   );

   // cosine select and clamp
   logic                       sc_v_ff;
   vang_pkg::vang_ang_tag_type sc_tag_ff;
   vang_pkg::vang_ang_tag_type sc_tag_in;
   logic [31:0]                ad_lim;
   logic [30:0]                c_unit;
   logic [30:0]                c_div;

   assign ad_lim = (dv_tag.ad > vang_pkg::ONE_Q28) ? vang_pkg::ONE_Q28 : dv_tag.ad;
   assign c_unit = {ad_lim[28:0], 2'b00};
   assign c_div  = (dv_sat || (dv_q > vang_pkg::ONE_Q30)) ? vang_pkg::ONE_Q30 : dv_q;

   assign sc_tag_in.neg   = dv_tag.neg;
   assign sc_tag_in.degen = dv_tag.degen;
   assign sc_tag_in.c     = dv_tag.unit_sel ? c_unit : c_div;

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_v_ff <= 1'b0;
      end else if (en) begin
         sc_v_ff <= dv_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sc_tag_ff <= sc_tag_in;
      end
   end

   // 1 - c^2
   logic                       sq_v_ff;
   logic [61:0]                rad_ff;
   vang_pkg::vang_ang_tag_type sq_tag_ff;
   logic [61:0]                cc;

   assign cc = sc_tag_ff.c * sc_tag_ff.c;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff <= 1'b0;
      end else if (en) begin
         sq_v_ff <= sc_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff    <= vang_pkg::ONE_Q60 - cc;
         sq_tag_ff <= sc_tag_ff;
      end
   end

   // sine root
   logic                       rt2_v;
   logic [30:0]                rt2_root;
   vang_pkg::vang_ang_tag_type rt2_tag;

   vang_isqrt #(.W(62), .TW(ANG_TW)) u_sin_root (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_v_ff),
      .in_val    (rad_ff),
      .in_tag    (sq_tag_ff),
      .out_valid (rt2_v),
      .out_root  (rt2_root),
      .out_tag   (rt2_tag)
   );

   // arctangent
   vang_pkg::vang_rot_tag_type cr_tag_in;
   vang_pkg::vang_rot_tag_type cr_tag;
   logic                       cr_v;
   logic signed [26:0]         cr_z;

   assign cr_tag_in.neg   = rt2_tag.neg;
   assign cr_tag_in.degen = rt2_tag.degen;

   vang_cordic #(.TW(ROT_TW)) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rt2_v),
      .in_x      (rt2_tag.c),
      .in_y      (rt2_root),
      .in_tag    (cr_tag_in),
      .out_valid (cr_v),
      .out_z     (cr_z),
      .out_tag   (cr_tag)
   );

   // fold to 0..pi and round to Q2.13
   logic [25:0]            z_clamp;
   logic [25:0]            z_full;
   logic [26:0]            z_round;
   vang_pkg::vang_rsp_type res;
   vang_pkg::vang_rsp_type out_data;
   logic                   out_valid;
   logic                   push;

   always_comb begin
      if (cr_z < 0) begin
         z_clamp = '0;
      end else if (cr_z[25:0] > vang_pkg::HALF_PI_Q24) begin
         z_clamp = vang_pkg::HALF_PI_Q24;
      end else begin
         z_clamp = cr_z[25:0];
      end
   end

   assign z_full  = cr_tag.neg ? (vang_pkg::PI_Q24 - z_clamp) : z_clamp;
   assign z_round = {1'b0, z_full} + vang_pkg::ROUND_HALF;

   assign res.angle      = cr_tag.degen ? 15'd0 : z_round[25:11];
   assign res.degenerate = cr_tag.degen;
   assign push           = cr_v && en;

   vang_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (res),
      .full      (buf_full),
      .out_valid (out_valid),
      .out_ready (rsp_ch.ready),
      .out_data  (out_data)
   );

   assign rsp_ch.valid      = out_valid;
   assign rsp_ch.angle      = out_data.angle;
   assign rsp_ch.degenerate = out_data.degenerate;

   `VANG_ASSERT_NOW(a_full_blocks_input, buf_full, !req_ch.ready, "input taken while buffer full")
   `VANG_ASSERT_NOW(a_degen_zero, rsp_ch.valid && rsp_ch.degenerate, rsp_ch.angle == 15'd0, "degenerate item with non-zero angle")
   `VANG_ASSERT_NOW(a_angle_range, rsp_ch.valid, rsp_ch.angle <= vang_pkg::ANGLE_MAX, "angle above pi")
   `VANG_ASSERT_NOW(a_unit_no_degen, s3_v_ff && s3_tag_ff.unit_sel, !s3_tag_ff.degen, "degenerate flagged in unit mode")
   `VANG_ASSERT_NEXT(a_stall_holds_tail, cr_v && buf_full, cr_v && ($past(cr_z) == cr_z), "pipeline tail moved during stall")

endmodule
